[rtl/bphd_pkg.sv]
// shared types and constants for the button press and hold detector
package bphd_pkg;

    localparam int unsigned NUM_BUTTONS_DEF = 2;
    localparam int unsigned AGE_W           = 16;
    localparam int unsigned APB_ADDR_W      = 4;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic [AGE_W-1:0] AGE_MAX        = '1;
    localparam logic [AGE_W-1:0] DEBOUNCE_RST   = 16'd40;
    localparam logic [AGE_W-1:0] HOLD_RST       = 16'd500;
    localparam logic             ACTIVE_LOW_RST = 1'b1;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_HOLD       = 2'd1,
        REG_ACTIVE_LOW = 2'd2,
        REG_ENABLE     = 2'd3
    } t_reg_idx;

    // settings shared by every button
    typedef struct packed {
        logic [AGE_W-1:0] debounce_ticks;
        logic [AGE_W-1:0] hold_ticks;
        logic             active_low;
    } t_cell_cfg;

    // per-button result of one tick
    typedef struct packed {
        logic press;
        logic hold;
        logic held;
    } t_cell_ev;

    function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
        return (v == AGE_MAX) ? AGE_MAX : v + 1'b1;
    endfunction

endpackage

[rtl/button_press_hold_detector.sv]
// button press and hold detector: config registers, button cells, output skid
// results: registered in the output register, or in the skid entry while the output stalls
// throughput: one request per clock while the skid entry is empty; the per-button update is
// compares and saturating 16-bit counters, and a two-entry output buffer takes stalls
// reset: synchronous active-low; config returns to 40/500/active low/all enabled,
// every button released and armed with ages at zero, output buffer empty
module button_press_hold_detector #(
    parameter int unsigned NUM_BUTTONS = bphd_pkg::NUM_BUTTONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [NUM_BUTTONS-1:0]            i_raw_levels,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [NUM_BUTTONS-1:0]            o_press_events,
    output logic [NUM_BUTTONS-1:0]            o_hold_events,
    output logic [NUM_BUTTONS-1:0]            o_held_now,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bphd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bphd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bphd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // configuration registers
    logic [bphd_pkg::AGE_W-1:0] r_debounce;
    logic [bphd_pkg::AGE_W-1:0] r_hold;
    logic                       r_active_low;
    logic [NUM_BUTTONS-1:0]     r_enable;

    bphd_pkg::t_reg_idx         reg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = bphd_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= bphd_pkg::DEBOUNCE_RST;
            r_hold       <= bphd_pkg::HOLD_RST;
            r_active_low <= bphd_pkg::ACTIVE_LOW_RST;
            r_enable     <= '1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bphd_pkg::REG_DEBOUNCE:   r_debounce   <= pwdata[bphd_pkg::AGE_W-1:0];
                bphd_pkg::REG_HOLD:       r_hold       <= pwdata[bphd_pkg::AGE_W-1:0];
                bphd_pkg::REG_ACTIVE_LOW: r_active_low <= pwdata[0];
                bphd_pkg::REG_ENABLE:     r_enable     <= pwdata[NUM_BUTTONS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            bphd_pkg::REG_DEBOUNCE:   prdata[bphd_pkg::AGE_W-1:0] = r_debounce;
            bphd_pkg::REG_HOLD:       prdata[bphd_pkg::AGE_W-1:0] = r_hold;
            bphd_pkg::REG_ACTIVE_LOW: prdata[0] = r_active_low;
            bphd_pkg::REG_ENABLE:     prdata[NUM_BUTTONS-1:0] = r_enable;
            default: ;
        endcase
    end

    // handshake and output buffer
    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic [NUM_BUTTONS-1:0] r_out_press, r_out_hold, r_out_held;
    logic [NUM_BUTTONS-1:0] r_skid_press, r_skid_hold, r_skid_held;
    logic [NUM_BUTTONS-1:0] n_press, n_hold, n_held;
    logic                   in_acc;
    logic                   out_take;
    logic                   out_free;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid & ~r_skid_valid;
    assign out_take   = r_out_valid & ~i_out_stall;
    assign out_free   = ~r_out_valid | out_take;

    bphd_pkg::t_cell_cfg cell_cfg;
    assign cell_cfg.debounce_ticks = r_debounce;
    assign cell_cfg.hold_ticks     = r_hold;
    assign cell_cfg.active_low     = r_active_low;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        bphd_pkg::t_cell_ev ev;

        bphd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (in_acc),
            .i_level  (i_raw_levels[g]),
            .i_enable (r_enable[g]),
            .i_cfg    (cell_cfg),
            .o_ev     (ev)
        );

        assign n_press[g] = ev.press;
        assign n_hold[g]  = ev.hold;
        assign n_held[g]  = ev.held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_free) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_acc && !out_free) begin
                r_skid_valid <= 1'b1;
            end
            if (r_skid_valid || in_acc) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // skid drains into the output first; new requests arrive only when it is empty
    always_ff @(posedge i_clk) begin
        if (r_skid_valid && out_free) begin
            r_out_press <= r_skid_press;
            r_out_hold  <= r_skid_hold;
            r_out_held  <= r_skid_held;
        end else if (in_acc && out_free) begin
            r_out_press <= n_press;
            r_out_hold  <= n_hold;
            r_out_held  <= n_held;
        end
        if (in_acc && !out_free) begin
            r_skid_press <= n_press;
            r_skid_hold  <= n_hold;
            r_skid_held  <= n_held;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_press_events = r_out_press;
    assign o_hold_events  = r_out_hold;
    assign o_held_now     = r_out_held;

    a_press_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_press & ~r_out_held) == '0))
        else $error("press event on a button not held");

    a_hold_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_hold & ~r_out_held) == '0))
        else $error("hold event on a button not held");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without an output entry");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request left no result");

endmodule

[rtl/bphd_cell.sv]
// per-button debounce, press and hold tracking
module bphd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_level,
    input  logic                i_enable,
    input  bphd_pkg::t_cell_cfg i_cfg,
    output bphd_pkg::t_cell_ev  o_ev
);

    logic                        r_last_level, n_last_level;
    logic [bphd_pkg::AGE_W-1:0]  r_flip_age,   n_flip_age;
    logic                        r_armed,      n_armed;
    logic                        r_pressed,    n_pressed;
    logic [bphd_pkg::AGE_W-1:0]  r_press_age,  n_press_age;
    logic                        r_hold_sent,  n_hold_sent;

    logic [bphd_pkg::AGE_W-1:0]  fa_inc;
    logic [bphd_pkg::AGE_W-1:0]  pa_inc;
    logic                        active;
    logic                        do_release;
    logic                        do_press;
    logic                        do_hold;

    always_comb begin
        fa_inc       = bphd_pkg::sat_inc(r_flip_age);
        pa_inc       = bphd_pkg::sat_inc(r_press_age);
        active       = i_cfg.active_low ? ~i_level : i_level;

        n_last_level = r_last_level;
        n_flip_age   = fa_inc;
        n_armed      = r_armed;
        n_pressed    = r_pressed;
        n_press_age  = pa_inc;
        n_hold_sent  = r_hold_sent;
        do_release   = 1'b0;
        do_press     = 1'b0;
        do_hold      = 1'b0;

        // a disabled button keeps its flags, only the ages run on
        if (i_enable) begin
            if (i_level != r_last_level) begin
                n_last_level = i_level;
                n_flip_age   = '0;
            end
            do_release = ~active & r_pressed;
            do_press   = active & ~r_pressed & r_armed & (n_flip_age > i_cfg.debounce_ticks);
            if (do_release) begin
                n_pressed = 1'b0;
                n_armed   = 1'b1;
            end else if (do_press) begin
                n_pressed   = 1'b1;
                n_armed     = 1'b0;
                n_press_age = '0;
                n_hold_sent = 1'b0;
            end
            do_hold = n_pressed & ~n_hold_sent & (n_press_age >= i_cfg.hold_ticks);
            if (do_hold) begin
                n_hold_sent = 1'b1;
            end
        end

        o_ev.press = do_press;
        o_ev.hold  = do_hold;
        o_ev.held  = i_enable & n_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b1;
            r_flip_age   <= '0;
            r_armed      <= 1'b1;
            r_pressed    <= 1'b0;
            r_press_age  <= '0;
            r_hold_sent  <= 1'b0;
        end else if (i_step) begin
            r_last_level <= n_last_level;
            r_flip_age   <= n_flip_age;
            r_armed      <= n_armed;
            r_pressed    <= n_pressed;
            r_press_age  <= n_press_age;
            r_hold_sent  <= n_hold_sent;
        end
    end

endmodule
